// ----- design/pal_pkg.sv -----
package pal_pkg;

    localparam int DEPTH  = 16;
    localparam int WORD_W = 32;
    localparam int OP_W   = 2;
    localparam int POS_W  = 4;
    localparam int CNT_W  = 5;
    localparam int ORD_W  = 2;
    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    // wide enough for position + count and for any length
    localparam int SUM_W  = ((LEN_W > CNT_W) ? LEN_W : CNT_W) + 1;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_MOVE   = 2'd2;
    localparam logic [OP_W-1:0] OP_RANGE  = 2'd3;

    localparam logic [ORD_W-1:0] ORD_NONE = 2'd0;
    localparam logic [ORD_W-1:0] ORD_UP   = 2'd1;
    localparam logic [ORD_W-1:0] ORD_DOWN = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic [POS_W-1:0]         position;
        logic [POS_W-1:0]         second_position;
        logic [CNT_W-1:0]         range_count;
        logic signed [WORD_W-1:0] value_in;
    } in_t;

    typedef struct packed {
        logic                     success;
        logic signed [WORD_W-1:0] removed_value;
        logic [LEN_W-1:0]         list_length;
        logic [ORD_W-1:0]         order_status;
    } out_t;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic finish;
    } cmd_t;

endpackage

// ----- design/pal_ctrl.sv -----
module pal_ctrl
    import pal_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EXEC   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- design/pal_datapath.sv -----
module pal_datapath
    import pal_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  in_t  in_data,
    output out_t out_data
);

    logic signed [WORD_W-1:0] cells_reg [DEPTH];
    logic signed [WORD_W-1:0] cells_next [DEPTH];
    logic [LEN_W-1:0]         length_reg, length_next;
    in_t                      item_reg;
    logic                     success_reg, success_next;
    logic signed [WORD_W-1:0] removed_reg, removed_next;
    out_t                     out_reg;

    logic [SUM_W-1:0]         len_s, pos_s, pos2_s, cnt_s;
    logic [SUM_W-1:0]         ins_p, mv_dst, drop_cnt;
    logic signed [WORD_W-1:0] taken;
    logic                     up, down;
    logic [ORD_W-1:0]         order;

    assign len_s    = SUM_W'(length_reg);
    assign pos_s    = SUM_W'(item_reg.position);
    assign pos2_s   = SUM_W'(item_reg.second_position);
    assign cnt_s    = SUM_W'(item_reg.range_count);
    assign ins_p    = (len_s == '0) ? '0 : pos_s;
    assign mv_dst   = (pos2_s < pos_s) ? pos2_s : pos2_s - SUM_W'(1);
    assign drop_cnt = (item_reg.opcode == OP_REMOVE) ? SUM_W'(1) : cnt_s;
    assign taken    = cells_reg[pos_s[IDX_W-1:0]];

    // legality, new length and the word handed back
    always_comb
    begin
        success_next = 1'b0;
        length_next  = length_reg;
        removed_next = '0;
        unique case (item_reg.opcode)
            OP_INSERT:
            begin
                success_next = (len_s == '0) ||
                               (len_s < SUM_W'(DEPTH) && pos_s <= len_s);
                length_next  = LEN_W'(len_s + SUM_W'(1));
            end
            OP_REMOVE:
            begin
                success_next = pos_s < len_s;
                length_next  = LEN_W'(len_s - SUM_W'(1));
                removed_next = success_next ? taken : '0;
            end
            OP_MOVE:
            begin
                success_next = (pos_s < len_s) && (pos2_s < len_s) && (pos_s != pos2_s);
            end
            OP_RANGE:
            begin
                success_next = (pos_s < len_s) && (pos_s + cnt_s <= len_s);
                length_next  = LEN_W'(len_s - cnt_s);
            end
        endcase
        if (!success_next)
            length_next = length_reg;
    end

    // every slot picks its new word in parallel
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic signed [WORD_W-1:0] prev_w, next_w;
        logic [SUM_W-1:0]         gi, src;

        if (g > 0)
        begin : g_prev
            assign prev_w = cells_reg[g-1];
        end
        else
        begin : g_prev0
            assign prev_w = cells_reg[g];
        end

        if (g < DEPTH - 1)
        begin : g_next
            assign next_w = cells_reg[g+1];
        end
        else
        begin : g_nextn
            assign next_w = cells_reg[g];
        end

        assign gi  = SUM_W'(g);
        assign src = gi + drop_cnt;

        always_comb
        begin
            cells_next[g] = cells_reg[g];
            unique case (item_reg.opcode)
                OP_INSERT:
                begin
                    if (gi == ins_p)
                        cells_next[g] = item_reg.value_in;
                    else if (gi > ins_p)
                        cells_next[g] = prev_w;
                end
                OP_REMOVE, OP_RANGE:
                begin
                    if (gi >= pos_s && src < SUM_W'(DEPTH))
                        cells_next[g] = cells_reg[src[IDX_W-1:0]];
                end
                OP_MOVE:
                begin
                    priority if (gi == mv_dst)
                        cells_next[g] = taken;
                    else if (mv_dst < pos_s && gi > mv_dst && gi <= pos_s)
                        cells_next[g] = prev_w;
                    else if (mv_dst > pos_s && gi >= pos_s && gi < mv_dst)
                        cells_next[g] = next_w;
                end
            endcase
        end
    end

    // adjacent compares over the valid slots
    always_comb
    begin
        up   = 1'b1;
        down = 1'b1;
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            if (SUM_W'(i + 1) < len_s)
            begin
                if (cells_reg[i] > cells_reg[i+1])
                    up = 1'b0;
                if (cells_reg[i] < cells_reg[i+1])
                    down = 1'b0;
            end
        end
        priority if (up)
            order = ORD_UP;
        else if (down)
            order = ORD_DOWN;
        else
            order = ORD_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            length_reg <= '0;
        else if (cmd.exec)
            length_reg <= length_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= in_data;
        if (cmd.exec)
        begin
            success_reg <= success_next;
            removed_reg <= removed_next;
            if (success_next)
                cells_reg <= cells_next;
        end
        if (cmd.finish)
        begin
            out_reg.success       <= success_reg;
            out_reg.removed_value <= removed_reg;
            out_reg.list_length   <= length_reg;
            out_reg.order_status  <= order;
        end
    end

    assign out_data = out_reg;

endmodule

// ----- design/positional_array_list.sv -----
// Positional array list: keeps up to DEPTH (16) signed 32-bit words in a dense
// ordered list held in flip-flops and takes one operation per input word:
// insert at a position (into an empty list always at slot 0), remove at a
// position and hand the word back, move an entry to a second position (one
// slot earlier when that position lies after the source), or drop a run of
// range_count entries. Each input word yields exactly one output word with
// success, removed_value (zero unless a remove succeeded), the new
// list_length and order_status (1 non-decreasing or empty, 2 non-increasing,
// 0 neither). An operation runs as a capture step, in which the word is
// accepted and captured, an execute step, in which every slot picks its new
// word in parallel, and a finish step, in which the adjacent signed compares
// for the order flag run and the result is loaded into the output register,
// raising out_valid. A new input word is taken only once the previous
// operation has finished; a result left waiting on out_ready holds back only
// the finish step of the next operation, not its acceptance.
module positional_array_list
    import pal_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    // command bundle from the sequencer to the list storage
    cmd_t cmd;

    // sequencer: capture, execute, finish
    pal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // list storage, shift network, order compares and output register
    pal_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .out_data (out_data)
    );

`ifndef SYNTHESIS
    // one word in flight at a time: no accept in the cycle after an accept
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while previous word is executing");

    // length never exceeds capacity
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.list_length <= LEN_W'(DEPTH)))
        else $error("list length beyond capacity");

    // empty list reports ascending order
    a_empty_up: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.list_length == '0) |-> (out_data.order_status == ORD_UP))
        else $error("empty list not reported as non-decreasing");

    // rejected operations hand back no word
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.success) |-> (out_data.removed_value == '0))
        else $error("rejected operation returned a word");
`endif

endmodule

// ----- dv/list_checker.sv -----
module list_checker
    import pal_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  in_t              in_data,
    input  logic             out_valid,
    input  logic             out_ready,
    input  out_t             out_data,
    output int               error_count,
    output int               pending,
    output logic [LEN_W-1:0] model_length
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow copy of the list, only slots below fill are meaningful
    logic signed [WORD_W-1:0] slots [DEPTH];
    int                       fill = 0;
    out_t                     awaited_results [$];
    out_t                     head;

    function automatic void put_word(int idx, logic signed [WORD_W-1:0] w);
        for (int i = fill; i > idx; i--)
            slots[i] = slots[i - 1];
        slots[idx] = w;
        fill++;
    endfunction

    function automatic logic signed [WORD_W-1:0] take_word(int idx);
        logic signed [WORD_W-1:0] w;
        w = slots[idx];
        for (int i = idx; i + 1 < fill; i++)
            slots[i] = slots[i + 1];
        fill--;
        return w;
    endfunction

    function automatic out_t next_list_result(in_t w);
        out_t                     r;
        logic signed [WORD_W-1:0] moved;
        int                       pos;
        int                       pos2;
        int                       cnt;
        logic                     up;
        logic                     down;
        r    = '0;
        pos  = int'(w.position);
        pos2 = int'(w.second_position);
        cnt  = int'(w.range_count);
        case (w.opcode)
            OP_INSERT:
            begin
                // empty list ignores the position
                if (fill == 0)
                begin
                    put_word(0, w.value_in);
                    r.success = 1'b1;
                end
                else if (fill < DEPTH && pos <= fill)
                begin
                    put_word(pos, w.value_in);
                    r.success = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (pos < fill)
                begin
                    r.removed_value = take_word(pos);
                    r.success       = 1'b1;
                end
            end
            OP_MOVE:
            begin
                if (pos < fill && pos2 < fill && pos != pos2)
                begin
                    moved = take_word(pos);
                    put_word((pos2 < pos) ? pos2 : pos2 - 1, moved);
                    r.success = 1'b1;
                end
            end
            OP_RANGE:
            begin
                if (pos < fill && pos + cnt <= fill)
                begin
                    for (int i = pos; i + cnt < fill; i++)
                        slots[i] = slots[i + cnt];
                    fill -= cnt;
                    r.success = 1'b1;
                end
            end
        endcase
        up   = 1'b1;
        down = 1'b1;
        for (int i = 0; i + 1 < fill; i++)
        begin
            if (slots[i] > slots[i + 1])
                up = 1'b0;
            if (slots[i] < slots[i + 1])
                down = 1'b0;
        end
        r.list_length  = LEN_W'(fill);
        r.order_status = up ? ORD_UP : (down ? ORD_DOWN : ORD_NONE);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaited_results.delete();
            fill         = 0;
            error_count  = 0;
            pending      = 0;
            model_length = '0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result word arrived with nothing expected");
                    error_count++;
                end
                else
                begin
                    head = awaited_results.pop_front();
                    if (out_data.success !== head.success)
                    begin
                        $error("success expected %0d got %0d",
                               head.success, out_data.success);
                        error_count++;
                    end
                    if (out_data.removed_value !== head.removed_value)
                    begin
                        $error("removed_value expected %0d got %0d",
                               head.removed_value, out_data.removed_value);
                        error_count++;
                    end
                    if (out_data.list_length !== head.list_length)
                    begin
                        $error("list_length expected %0d got %0d",
                               head.list_length, out_data.list_length);
                        error_count++;
                    end
                    if (out_data.order_status !== head.order_status)
                    begin
                        $error("order_status expected %0d got %0d",
                               head.order_status, out_data.order_status);
                        error_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                awaited_results.push_back(next_list_result(in_data));
            pending      = awaited_results.size();
            model_length = LEN_W'(fill);
        end
    end

endmodule

// ----- dv/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pal_pkg::*;

    // quiet cycles allowed before giving up, well above the receiver hold-off
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 120;
    localparam int TOP_POS        = (1 << POS_W) - 1;
    localparam int PHASE_ITEMS    = 170;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    in_t              in_data;
    logic             out_valid;
    logic             out_ready;
    out_t             out_data;
    int               error_count;
    int               pending;
    logic [LEN_W-1:0] model_length;

    // knobs for the idling phases, written by the stimulus process only, and the watchdog count
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_phase    = 0;
    int quiet_cycles  = 0;

    positional_array_list uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    list_checker list_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .error_count  (error_count),
        .pending      (pending),
        .model_length (model_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // pack one operation word
    function automatic in_t word_of(logic [OP_W-1:0] op, int pos, int pos2, int cnt,
                                    logic [WORD_W-1:0] v);
        in_t w;
        w.opcode          = op;
        w.position        = POS_W'(pos);
        w.second_position = POS_W'(pos2);
        w.range_count     = CNT_W'(cnt);
        w.value_in        = v;
        return w;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance;
    // valid stays high across back-to-back words, only dropped for idle gaps
    task automatic send_word(in_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // random words steered by the current list length so most operations land
    // inside the list, plus noise words and monotone runs for the order flag
    task automatic run_phase(int n_items);
        int                       sent;
        int                       fill;
        int                       pick;
        int                       pos;
        int                       pos2;
        int                       cnt;
        int                       run_len;
        int                       step;
        logic                     rising;
        logic signed [WORD_W-1:0] v;
        sent = 0;
        while (sent < n_items)
        begin
            fill = int'(model_length);
            pick = $urandom_range(99);
            if (pick < 6)
            begin
                // clear the list, then append a monotone run, past full at times
                if (fill > 0)
                    send_word(word_of(OP_RANGE, 0, 0, fill, '0));
                run_len = $urandom_range(DEPTH + 2, 3);
                rising  = 1'($urandom_range(1));
                v       = WORD_W'($urandom_range(2000)) - 1000;
                for (int i = 0; i < run_len; i++)
                begin
                    send_word(word_of(OP_INSERT, (i > TOP_POS) ? TOP_POS : i, 0, 0, v));
                    step = $urandom_range(500);
                    v    = rising ? v + step : v - step;
                end
                sent += run_len + 1;
            end
            else
            begin
                pos  = $urandom_range((fill > TOP_POS) ? TOP_POS : fill);
                pos2 = $urandom_range((fill > TOP_POS) ? TOP_POS : fill);
                // small values give ties, full range hits every bit
                if ($urandom_range(3) == 0)
                    v = WORD_W'($urandom_range(6)) - 3;
                else
                    v = $urandom;
                if (pick < 14)
                    send_word(word_of(OP_W'($urandom_range(3)), $urandom_range(TOP_POS),
                                      $urandom_range(TOP_POS), $urandom_range(31),
                                      $urandom));
                else if (pick < 48 || fill < 3)
                    send_word(word_of(OP_INSERT,
                                      $urandom_range((fill + 1 > TOP_POS) ? TOP_POS
                                                                           : fill + 1),
                                      pos2, 0, v));
                else if (pick < 65)
                    send_word(word_of(OP_REMOVE, pos, pos2, 0, v));
                else if (pick < 86)
                    send_word(word_of(OP_MOVE, pos, pos2, 0, v));
                else
                begin
                    cnt = ($urandom_range(4) != 0) ? $urandom_range(3)
                                                   : $urandom_range(DEPTH + 1);
                    send_word(word_of(OP_RANGE, pos, pos2, cnt, v));
                end
                sent++;
            end
        end
    endtask

    // receiver: random stalls, and a long hold-off whenever hold_phase moves
    initial
    begin
        int hold_left;
        int seen_hold;
        hold_left = 0;
        seen_hold = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_phase != seen_hold)
            begin
                seen_hold = hold_phase;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
                out_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty list rejections
        send_word(word_of(OP_REMOVE, 0, 0, 0, '0));
        // insert into empty list goes to slot 0 whatever the position
        send_word(word_of(OP_INSERT, 9, 0, 0, 32'h7FFF_FFFF));
        // past the end
        send_word(word_of(OP_INSERT, 5, 0, 0, 32'd7));
        // append at the end, then at the front
        send_word(word_of(OP_INSERT, 1, 0, 0, 32'h8000_0000));
        send_word(word_of(OP_INSERT, 0, 0, 0, '1));
        send_word(word_of(OP_REMOVE, 3, 0, 0, '0));
        send_word(word_of(OP_REMOVE, 1, 0, 0, '0));
        // move to a later slot lands one before it, then move earlier
        send_word(word_of(OP_MOVE, 0, 1, 0, '0));
        send_word(word_of(OP_MOVE, 1, 0, 0, '0));
        // equal positions and destination past the end
        send_word(word_of(OP_MOVE, 1, 1, 0, '0));
        send_word(word_of(OP_MOVE, 0, 5, 0, '0));
        // zero count inside the list, then ranges running off the end
        send_word(word_of(OP_RANGE, 0, 0, 0, '0));
        send_word(word_of(OP_RANGE, 1, 0, 2, '0));
        send_word(word_of(OP_RANGE, 0, 0, 31, '0));
        // fill to the brim in ascending order
        for (int i = 0; i < DEPTH - 2; i++)
            send_word(word_of(OP_INSERT, i + 2, 0, 0, WORD_W'(i)));
        send_word(word_of(OP_INSERT, 3, 0, 0, 32'd99));
        send_word(word_of(OP_MOVE, TOP_POS, 0, 0, '0));
        send_word(word_of(OP_RANGE, TOP_POS, 0, 1, '0));
        send_word(word_of(OP_RANGE, 0, 0, DEPTH - 1, '0));

        // random phases: no idling (with the long receiver hold-off first),
        // sender gaps, receiver stalls, both
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 48 : ((ph == 3) ? 23 : 0);
            stall_pct     = (ph == 2) ? 48 : ((ph == 3) ? 23 : 0);
            if (ph == 0)
                hold_phase++;
            run_phase(PHASE_ITEMS);
            in_valid = 1'b0;
            while (pending != 0)
                @(negedge clk);
        end

        // drain, then give stray words a chance to show up
        stall_pct = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
